// ===== hdl/qfft_pkg.sv =====
// ----------------------------------------------------------------------------
// qfft_pkg
// Shared types, constants and Q15 arithmetic helpers for the spectrum core.
// ----------------------------------------------------------------------------
`default_nettype none

package qfft_pkg;

	localparam int FFT_SIZE  = 1024;
	localparam int LOG_N     = $clog2(FFT_SIZE);
	localparam int TW_W      = LOG_N - 1;
	localparam int S_W       = $clog2(LOG_N);
	localparam int SUM_W     = 16 + LOG_N;
	localparam int Q_DEPTH   = 4;
	localparam int Q_PTR_W   = $clog2(Q_DEPTH);
	localparam int Q15_HALF  = 1 << 14;
	localparam int Q15_SHIFT = 15;

	localparam logic KIND_FRAME = 1'b0;
	localparam logic KIND_BIN   = 1'b1;

	typedef enum logic [1:0] {
		OP_WIN    = 2'd0,
		OP_TW     = 2'd1,
		OP_SAMPLE = 2'd2,
		OP_READ   = 2'd3
	} op_t;

	typedef struct packed {
		op_t                op;
		logic [LOG_N-1:0]   addr;
		logic signed [15:0] data_a;
		logic signed [15:0] data_b;
	} item_t;

	typedef struct packed {
		logic valid;
		logic pop;
	} q_ctrl_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SUM_A,
		ST_SUM_B,
		ST_MEAN,
		ST_WIN_A,
		ST_WIN_B,
		ST_WIN_C,
		ST_BF_RD,
		ST_BF_MUL,
		ST_BF_ADD,
		ST_BF_WE,
		ST_BF_WO,
		ST_DONE,
		ST_RD_A,
		ST_RD_B,
		ST_RD_C
	} state_t;

	function automatic logic signed [15:0] sat16(input logic signed [18:0] v);
		if (v > 19'sd32767)
			return 16'sh7fff;
		else if (v < -19'sd32768)
			return 16'sh8000;
		else
			return v[15:0];
	endfunction

	// round half away from zero, >> 15
	function automatic logic signed [16:0] q15_rnd(input logic signed [31:0] p);
		logic [31:0] mag;
		logic [16:0] r;
		mag = p[31] ? 32'(-p) : 32'(p);
		r   = 17'((mag + 32'(Q15_HALF)) >> Q15_SHIFT);
		return p[31] ? -$signed(r) : $signed(r);
	endfunction

	function automatic logic signed [15:0] win_rnd(input logic signed [32:0] p);
		logic [32:0]        mag;
		logic [17:0]        r;
		logic signed [18:0] v;
		mag = p[32] ? 33'(-p) : 33'(p);
		r   = 18'((mag + 33'(Q15_HALF)) >> Q15_SHIFT);
		v   = p[32] ? -$signed({1'b0, r}) : $signed({1'b0, r});
		return sat16(v);
	endfunction

	// halve, ties to even on the magnitude
	function automatic logic signed [15:0] halve_even(input logic signed [16:0] v);
		logic signed [17:0] ext;
		logic [17:0]        mag;
		logic [17:0]        r;
		ext = 18'(v);
		mag = ext[17] ? 18'(-ext) : 18'(ext);
		r   = mag >> 1;
		if (mag[0] && r[0])
			r = r + 18'd1;
		return sat16(ext[17] ? -$signed({1'b0, r}) : $signed({1'b0, r}));
	endfunction

	function automatic logic [LOG_N-1:0] bit_rev(input logic [LOG_N-1:0] a);
		logic [LOG_N-1:0] r;
		for (int b = 0; b < LOG_N; b++)
			r[b] = a[LOG_N-1-b];
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== hdl/qfft_front.sv =====
// ----------------------------------------------------------------------------
// qfft_front
// Input stage: takes stream transactions, decodes op and wraps the index to
// its table size, and buffers items in a short queue for the engine.
// ----------------------------------------------------------------------------
`default_nettype none

module qfft_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_tvalid,
	output      logic              s_tready,
	input  wire logic [47:0]       s_tdata,  // index[9:0], data_a[25:10], data_b[41:26]
	input  wire logic [1:0]        s_tuser,  // op[1:0]
	output      qfft_pkg::item_t   head,
	input  wire logic              pop,
	output      logic              head_valid
);

	qfft_pkg::item_t                  queue_q [qfft_pkg::Q_DEPTH];
	logic [qfft_pkg::Q_PTR_W-1:0]     wr_ptr_q, rd_ptr_q;
	logic [qfft_pkg::Q_PTR_W:0]       count_q;
	qfft_pkg::item_t                  item_d;
	logic                             push;

	always_comb begin
		item_d.op     = qfft_pkg::op_t'(s_tuser);
		item_d.data_a = $signed(s_tdata[25:10]);
		item_d.data_b = $signed(s_tdata[41:26]);
		if (item_d.op == qfft_pkg::OP_TW)
			item_d.addr = qfft_pkg::LOG_N'(qfft_pkg::TW_W'(s_tdata[9:0]));
		else
			item_d.addr = qfft_pkg::LOG_N'(s_tdata[9:0]);
	end

	assign s_tready   = (count_q != (qfft_pkg::Q_PTR_W+1)'(qfft_pkg::Q_DEPTH));
	assign push       = s_tvalid && s_tready;
	assign head_valid = (count_q != '0);
	assign head       = queue_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			queue_q[wr_ptr_q] <= item_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			count_q <= count_q + (qfft_pkg::Q_PTR_W+1)'(push)
			                   - (qfft_pkg::Q_PTR_W+1)'(pop);
		end
	end

endmodule

`default_nettype wire

// ===== hdl/qfft_back.sv =====
// ----------------------------------------------------------------------------
// qfft_back
// Engine: table and sample stores, mean and window pass, in-place radix-2
// butterflies over the bin memory, bin reads, and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module qfft_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire qfft_pkg::item_t   head,
	input  wire logic              head_valid,
	output      qfft_pkg::q_ctrl_t qctl,
	output      logic              m_tvalid,
	input  wire logic              m_tready,
	output      logic [71:0]       m_tdata,  // bin_real[15:0], bin_imag[31:16], bin_energy[64:32]
	output      logic [0:0]        m_tuser   // kind
);

	localparam int N  = qfft_pkg::FFT_SIZE;
	localparam int LN = qfft_pkg::LOG_N;
	localparam int TW = qfft_pkg::TW_W;
	localparam int SW = qfft_pkg::S_W;
	localparam int SM = qfft_pkg::SUM_W;

	logic signed [15:0] sample_mem [N];
	logic signed [15:0] window_mem [N];
	logic [31:0]        tw_mem     [N/2];
	logic [31:0]        bin_mem    [N];

	qfft_pkg::state_t   state_q, state_d;
	logic [LN-1:0]      cnt_q, i_q, rd_addr_q;
	logic [TW-1:0]      j_q;
	logic [SW-1:0]      s_q;
	logic signed [SM-1:0] sum_q, mean_d;
	logic signed [15:0] mean_q;

	logic signed [15:0] s_rdata_q, w_rdata_q;
	logic [31:0]        t_rdata_q, b_rdata0_q, b_rdata1_q;
	logic signed [32:0] win_p_s1;
	logic signed [31:0] p_rr_s1, p_ii_s1, p_ri_s1, p_ir_s1, sq_re_s1, sq_im_s1;
	logic signed [15:0] pr_s2, pi_s2;
	logic [31:0]        e_s1, o_res_q, rd_s1;
	logic               m_valid_q;
	logic [71:0]        m_data_q;
	logic               m_kind_q;

	logic [TW-1:0]      hmask, off;
	logic [LN-1:0]      e_addr, o_addr, b_raddr0, b_waddr;
	logic [TW-1:0]      t_addr;
	logic               b_we, out_free, emit;
	logic [31:0]        b_wdata;
	logic signed [16:0] c_d;
	logic signed [15:0] pr, pi, he_r, he_i, ho_r, ho_i;
	logic [31:0]        en_sum;

	// butterfly addressing
	always_comb begin
		hmask  = ~({TW{1'b1}} << s_q);
		off    = j_q & hmask;
		e_addr = ((LN'(j_q) >> s_q) << (s_q + 1'b1)) | LN'(off);
		o_addr = e_addr | (LN'(1) << s_q);
		t_addr = TW'(off << (LN - 1 - int'(s_q)));
	end

	always_comb begin
		pr = qfft_pkg::sat16(19'(qfft_pkg::q15_rnd(p_rr_s1)) - 19'(qfft_pkg::q15_rnd(p_ii_s1)));
		pi = qfft_pkg::sat16(19'(qfft_pkg::q15_rnd(p_ri_s1)) + 19'(qfft_pkg::q15_rnd(p_ir_s1)));
		he_r = qfft_pkg::halve_even(17'($signed(e_s1[31:16])) + 17'(pr_s2));
		he_i = qfft_pkg::halve_even(17'($signed(e_s1[15:0])) + 17'(pi_s2));
		ho_r = qfft_pkg::halve_even(17'($signed(e_s1[31:16])) - 17'(pr_s2));
		ho_i = qfft_pkg::halve_even(17'($signed(e_s1[15:0])) - 17'(pi_s2));
		c_d  = 17'(s_rdata_q) - 17'(mean_q);
		mean_d = sum_q[SM-1] ? (sum_q + SM'(N - 1)) >>> LN : sum_q >>> LN;
		en_sum = 32'(sq_re_s1) + 32'(sq_im_s1);
	end

	assign out_free = !m_valid_q || m_tready;

	always_comb begin
		state_d  = state_q;
		qctl.valid = head_valid;
		qctl.pop = 1'b0;
		b_we     = 1'b0;
		b_waddr  = e_addr;
		b_wdata  = {he_r, he_i};
		b_raddr0 = rd_addr_q;
		emit     = 1'b0;
		unique case (state_q)
			qfft_pkg::ST_IDLE: begin
				if (head_valid) begin
					qctl.pop = 1'b1;
					if (head.op == qfft_pkg::OP_SAMPLE && cnt_q == LN'(N - 1))
						state_d = qfft_pkg::ST_SUM_A;
					else if (head.op == qfft_pkg::OP_READ)
						state_d = qfft_pkg::ST_RD_A;
				end
			end
			qfft_pkg::ST_SUM_A: state_d = qfft_pkg::ST_SUM_B;
			qfft_pkg::ST_SUM_B: state_d = (i_q == LN'(N - 1)) ? qfft_pkg::ST_MEAN
			                                                 : qfft_pkg::ST_SUM_A;
			qfft_pkg::ST_MEAN:  state_d = qfft_pkg::ST_WIN_A;
			qfft_pkg::ST_WIN_A: state_d = qfft_pkg::ST_WIN_B;
			qfft_pkg::ST_WIN_B: state_d = qfft_pkg::ST_WIN_C;
			qfft_pkg::ST_WIN_C: begin
				b_we    = 1'b1;
				b_waddr = qfft_pkg::bit_rev(i_q);
				b_wdata = {qfft_pkg::win_rnd(win_p_s1), 16'h0000};
				state_d = (i_q == LN'(N - 1)) ? qfft_pkg::ST_BF_RD : qfft_pkg::ST_WIN_A;
			end
			qfft_pkg::ST_BF_RD: begin
				b_raddr0 = e_addr;
				state_d  = qfft_pkg::ST_BF_MUL;
			end
			qfft_pkg::ST_BF_MUL: begin
				b_raddr0 = e_addr;
				state_d  = qfft_pkg::ST_BF_ADD;
			end
			qfft_pkg::ST_BF_ADD: state_d = qfft_pkg::ST_BF_WE;
			qfft_pkg::ST_BF_WE: begin
				b_we    = 1'b1;
				state_d = qfft_pkg::ST_BF_WO;
			end
			qfft_pkg::ST_BF_WO: begin
				b_we    = 1'b1;
				b_waddr = o_addr;
				b_wdata = o_res_q;
				if (j_q == TW'(N/2 - 1) && s_q == SW'(LN - 1))
					state_d = qfft_pkg::ST_DONE;
				else
					state_d = qfft_pkg::ST_BF_RD;
			end
			qfft_pkg::ST_DONE: begin
				emit = out_free;
				if (out_free)
					state_d = qfft_pkg::ST_IDLE;
			end
			qfft_pkg::ST_RD_A: state_d = qfft_pkg::ST_RD_B;
			qfft_pkg::ST_RD_B: state_d = qfft_pkg::ST_RD_C;
			qfft_pkg::ST_RD_C: begin
				emit = out_free;
				if (out_free)
					state_d = qfft_pkg::ST_IDLE;
			end
			default: state_d = qfft_pkg::ST_IDLE;
		endcase
	end

	// stores
	always_ff @(posedge clk) begin
		if (state_q == qfft_pkg::ST_IDLE && head_valid) begin
			if (head.op == qfft_pkg::OP_WIN)
				window_mem[head.addr] <= head.data_a;
			if (head.op == qfft_pkg::OP_TW)
				tw_mem[TW'(head.addr)] <= {head.data_a, head.data_b};
			if (head.op == qfft_pkg::OP_SAMPLE)
				sample_mem[cnt_q] <= head.data_a;
		end
		s_rdata_q <= sample_mem[i_q];
		w_rdata_q <= window_mem[i_q];
		t_rdata_q <= tw_mem[t_addr];
	end

	always_ff @(posedge clk) begin
		if (b_we)
			bin_mem[b_waddr] <= b_wdata;
		b_rdata0_q <= bin_mem[b_raddr0];
		b_rdata1_q <= bin_mem[o_addr];
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (state_q == qfft_pkg::ST_IDLE && head_valid && head.op == qfft_pkg::OP_READ)
			rd_addr_q <= head.addr;
		if (state_q == qfft_pkg::ST_MEAN)
			mean_q <= 16'(mean_d);
		win_p_s1 <= 33'(c_d) * 33'(w_rdata_q);
		p_rr_s1 <= $signed(t_rdata_q[31:16]) * $signed(b_rdata1_q[31:16]);
		p_ii_s1 <= $signed(t_rdata_q[15:0])  * $signed(b_rdata1_q[15:0]);
		p_ri_s1 <= $signed(t_rdata_q[31:16]) * $signed(b_rdata1_q[15:0]);
		p_ir_s1 <= $signed(t_rdata_q[15:0])  * $signed(b_rdata1_q[31:16]);
		e_s1    <= b_rdata0_q;
		if (state_q == qfft_pkg::ST_BF_ADD) begin
			pr_s2 <= pr;
			pi_s2 <= pi;
		end
		if (state_q == qfft_pkg::ST_BF_WE)
			o_res_q <= {ho_r, ho_i};
		if (state_q == qfft_pkg::ST_RD_B) begin
			rd_s1    <= b_rdata0_q;
			sq_re_s1 <= $signed(b_rdata0_q[31:16]) * $signed(b_rdata0_q[31:16]);
			sq_im_s1 <= $signed(b_rdata0_q[15:0])  * $signed(b_rdata0_q[15:0]);
		end
		if (emit) begin
			if (state_q == qfft_pkg::ST_DONE) begin
				m_data_q <= '0;
				m_kind_q <= qfft_pkg::KIND_FRAME;
			end else begin
				m_data_q <= {7'd0, en_sum, 1'b0, rd_s1[15:0], rd_s1[31:16]};
				m_kind_q <= qfft_pkg::KIND_BIN;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= qfft_pkg::ST_IDLE;
		else
			state_q <= state_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			i_q       <= '0;
			j_q       <= '0;
			s_q       <= '0;
			sum_q     <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (state_q == qfft_pkg::ST_IDLE && head_valid && head.op == qfft_pkg::OP_SAMPLE)
				cnt_q <= cnt_q + 1'b1;
			if (state_q == qfft_pkg::ST_IDLE) begin
				i_q   <= '0;
				j_q   <= '0;
				s_q   <= '0;
				sum_q <= '0;
			end
			if (state_q == qfft_pkg::ST_SUM_B) begin
				sum_q <= sum_q + SM'(s_rdata_q);
				i_q   <= i_q + 1'b1;
			end
			if (state_q == qfft_pkg::ST_WIN_C)
				i_q <= i_q + 1'b1;
			if (state_q == qfft_pkg::ST_BF_WO) begin
				j_q <= j_q + 1'b1;
				if (j_q == TW'(N/2 - 1))
					s_q <= s_q + 1'b1;
			end
			if (emit)
				m_valid_q <= 1'b1;
			else if (m_tready)
				m_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;
	assign m_tuser  = m_kind_q;

endmodule

`default_nettype wire

// ===== hdl/q15_windowed_fft_spectrum_core.sv =====
// ----------------------------------------------------------------------------
// q15_windowed_fft_spectrum_core
// Q15 mean-removed, windowed radix-2 FFT with table loads and bin reads.
// ----------------------------------------------------------------------------
// Loads and samples are taken from the queue head in ST_IDLE; a bin read passes
// through ST_RD_A, ST_RD_B and ST_RD_C to the output register. The full-frame
// sample then runs the mean pass (ST_SUM_A, ST_SUM_B per sample), the window
// pass (ST_WIN_A to ST_WIN_C per sample) and the butterfly sequence: read,
// multiply, round, then two writes on the single write port of the bin memory.
// Reset clears control, the queue and the sample count; stores are not cleared.
`default_nettype none

module q15_windowed_fft_spectrum_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output      logic        s_tready,
	input  wire logic [47:0] s_tdata,  // index[9:0], data_a[25:10], data_b[41:26]
	input  wire logic [1:0]  s_tuser,  // op[1:0]
	output      logic        m_tvalid,
	input  wire logic        m_tready,
	output      logic [71:0] m_tdata,  // bin_real[15:0], bin_imag[31:16], bin_energy[64:32]
	output      logic [0:0]  m_tuser   // kind
);

	qfft_pkg::item_t   head;
	qfft_pkg::q_ctrl_t qctl;
	logic              head_valid;

	qfft_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.head       (head),
		.pop        (qctl.pop),
		.head_valid (head_valid)
	);

	qfft_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_valid (head_valid),
		.qctl       (qctl),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser)
	);

	a_frame_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] == qfft_pkg::KIND_FRAME |-> m_tdata == '0)
		else $error("frame result carries data");

	a_energy_even: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[32] == 1'b0)
		else $error("odd energy");

	a_energy_top: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[64] |-> m_tdata[31:0] == 32'h8000_8000)
		else $error("energy overflow bit without full-scale bin");

	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		qctl.pop |-> qctl.valid)
		else $error("pop from empty queue");

endmodule

`default_nettype wire

// ===== tb/q15_windowed_fft_spectrum_checker.sv =====
// ----------------------------------------------------------------------------
// q15_windowed_fft_spectrum_checker
// Watches both stream channels of the spectrum core. It predicts every result
// from the accepted input transactions and compares it field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module q15_windowed_fft_spectrum_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	input  wire logic        s_tready,
	input  wire logic [47:0] s_tdata,
	input  wire logic [1:0]  s_tuser,
	input  wire logic        m_tvalid,
	input  wire logic        m_tready,
	input  wire logic [71:0] m_tdata,
	input  wire logic [0:0]  m_tuser,
	output int               fail_count,
	output int               pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic               kind;
		logic signed [15:0] re;
		logic signed [15:0] im;
		logic [32:0]        energy;
	} spec_res_t;

	logic signed [15:0] smp_mem [qfft_pkg::FFT_SIZE];
	logic signed [15:0] win_mem [qfft_pkg::FFT_SIZE];
	logic signed [15:0] tw_re [qfft_pkg::FFT_SIZE/2];
	logic signed [15:0] tw_im [qfft_pkg::FFT_SIZE/2];
	logic signed [15:0] bin_re [qfft_pkg::FFT_SIZE];
	logic signed [15:0] bin_im [qfft_pkg::FFT_SIZE];
	int                 smp_cnt;
	spec_res_t          expected_bins[$];

	function automatic longint clip16(longint v);
		if (v > 32767)
			return 32767;
		if (v < -32768)
			return -32768;
		return v;
	endfunction

	function automatic longint q15_scale(longint v);
		longint mag;
		longint r;
		mag = v < 0 ? -v : v;
		r = (mag + 16384) >>> 15;
		return v < 0 ? -r : r;
	endfunction

	function automatic longint half_tie_even(longint v);
		longint mag;
		longint r;
		mag = v < 0 ? -v : v;
		r = mag >>> 1;
		if (mag[0] && r[0])
			r = r + 1;
		return clip16(v < 0 ? -r : r);
	endfunction

	function automatic void transform_frame();
		longint             total;
		longint             avg;
		logic [9:0]         rv;
		logic signed [15:0] t;
		longint             pr, pi, er, ei, o_r, o_i, wr, wi;
		int                 h, stp, e, o, k;
		total = 0;
		for (int i = 0; i < qfft_pkg::FFT_SIZE; i++)
			total += smp_mem[i];
		avg = total / qfft_pkg::FFT_SIZE;
		for (int i = 0; i < qfft_pkg::FFT_SIZE; i++) begin
			bin_re[i] = 16'(clip16(q15_scale((longint'(smp_mem[i]) - avg) * win_mem[i])));
			bin_im[i] = 0;
		end
		for (int i = 0; i < qfft_pkg::FFT_SIZE; i++) begin
			for (int b = 0; b < 10; b++)
				rv[b] = i[9-b];
			if (i < rv) begin
				t = bin_re[i]; bin_re[i] = bin_re[rv]; bin_re[rv] = t;
				t = bin_im[i]; bin_im[i] = bin_im[rv]; bin_im[rv] = t;
			end
		end
		for (int len = 2; len <= qfft_pkg::FFT_SIZE; len <<= 1) begin
			h = len >> 1;
			stp = qfft_pkg::FFT_SIZE / len;
			for (int blk = 0; blk < qfft_pkg::FFT_SIZE; blk += len)
				for (int off = 0; off < h; off++) begin
					e = blk + off;
					o = e + h;
					k = (off * stp) & (qfft_pkg::FFT_SIZE/2 - 1);
					wr = tw_re[k]; wi = tw_im[k];
					o_r = bin_re[o]; o_i = bin_im[o];
					pr = clip16(q15_scale(wr * o_r) - q15_scale(wi * o_i));
					pi = clip16(q15_scale(wr * o_i) + q15_scale(wi * o_r));
					er = bin_re[e]; ei = bin_im[e];
					bin_re[e] = 16'(half_tie_even(er + pr));
					bin_im[e] = 16'(half_tie_even(ei + pi));
					bin_re[o] = 16'(half_tie_even(er - pr));
					bin_im[o] = 16'(half_tie_even(ei - pi));
				end
		end
	endfunction

	function automatic void predict_item(qfft_pkg::op_t op, logic [9:0] idx,
		logic signed [15:0] a, logic signed [15:0] b);
		spec_res_t r;
		longint    x, y;
		case (op)
			qfft_pkg::OP_WIN: win_mem[idx] = a;
			qfft_pkg::OP_TW: begin
				tw_re[idx[8:0]] = a;
				tw_im[idx[8:0]] = b;
			end
			qfft_pkg::OP_SAMPLE: begin
				smp_mem[smp_cnt] = a;
				smp_cnt++;
				if (smp_cnt == qfft_pkg::FFT_SIZE) begin
					smp_cnt = 0;
					transform_frame();
					r.kind = qfft_pkg::KIND_FRAME; r.re = 0; r.im = 0; r.energy = 0;
					expected_bins.push_back(r);
				end
			end
			default: begin
				x = bin_re[idx];
				y = bin_im[idx];
				r.kind = qfft_pkg::KIND_BIN; r.re = bin_re[idx]; r.im = bin_im[idx];
				r.energy = 33'(2 * (x * x + y * y));
				expected_bins.push_back(r);
			end
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin
		spec_res_t exp_r;
		if (!arst_n) begin
			smp_cnt = 0;
			fail_count = 0;
			pending = 0;
		end else begin
			if (s_tvalid && s_tready)
				predict_item(qfft_pkg::op_t'(s_tuser), s_tdata[9:0], s_tdata[25:10],
					s_tdata[41:26]);
			if (m_tvalid && m_tready) begin
				if (expected_bins.size() == 0) begin
					$display("%0t: unexpected result kind=%0d data=%h", $time, m_tuser,
						m_tdata);
					fail_count++;
				end else begin
					exp_r = expected_bins.pop_front();
					if (m_tuser[0] !== exp_r.kind || m_tdata[15:0] !== exp_r.re ||
						m_tdata[31:16] !== exp_r.im || m_tdata[64:32] !== exp_r.energy) begin
						$display("%0t: mismatch expected kind=%0d re=%0d im=%0d en=%0d",
							$time, exp_r.kind, exp_r.re, exp_r.im, exp_r.energy);
						$display("%0t:          actual kind=%0d re=%0d im=%0d en=%0d",
							$time, m_tuser[0], $signed(m_tdata[15:0]),
							$signed(m_tdata[31:16]), m_tdata[64:32]);
						fail_count++;
					end
				end
			end
			pending = expected_bins.size();
		end
	end

endmodule

`default_nettype wire

// ===== tb/q15_windowed_fft_spectrum_core_test.sv =====
// ----------------------------------------------------------------------------
// q15_windowed_fft_spectrum_core_test
// Fills the window and twiddle tables, streams frames of samples and bin
// reads with bursty input and a stalling output; a checker predicts results.
// ----------------------------------------------------------------------------
`default_nettype none

module q15_windowed_fft_spectrum_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [47:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [71:0] m_tdata;
	logic [0:0]  m_tuser;
	int          fail_count;
	int          pending;
	int          burst_left;
	bit          hold_req;

	q15_windowed_fft_spectrum_core u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	q15_windowed_fft_spectrum_checker u_chk (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.fail_count(fail_count), .pending(pending)
	);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	initial begin
		#12ms;
		$display("Test completed with failures");
		$finish;
	end

	// output side: random stalls, quiet stretches, and one long hold-off
	initial begin
		int hold;
		m_tready = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				m_tready <= 0;
				for (hold = 0; hold < 3000; hold++)
					@(posedge clk);
				hold_req = 0;
			end else if ((($time / 50000) % 3) == 0)
				m_tready <= 1;
			else
				m_tready <= ($urandom_range(0, 3) != 0);
		end
	end

	task automatic send_item(qfft_pkg::op_t op, logic [9:0] idx, logic [15:0] a,
		logic [15:0] b);
		int gap;
		if (burst_left == 0) begin
			s_tvalid <= 0;
			gap = $urandom_range(1, 12);
			repeat (gap) @(posedge clk);
			burst_left = $urandom_range(1, 40);
		end
		s_tvalid <= 1;
		s_tuser  <= op;
		s_tdata  <= {6'b0, b, a, idx};
		do @(posedge clk); while (!s_tready);
		burst_left--;
	endtask

	function automatic logic [15:0] pick_value();
		case ($urandom_range(0, 7))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'($urandom_range(0, 511)) - 16'd256;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic run_sample_frame();
		for (int i = 0; i < qfft_pkg::FFT_SIZE; i++)
			send_item(qfft_pkg::OP_SAMPLE, 10'($urandom), (i % 64 == 0) ? 16'h8000 :
				(i % 64 == 1) ? 16'h7fff : 16'($urandom_range(0, 8191)) - 16'd4096,
				16'($urandom));
	endtask

	initial begin
		int r;
		s_tvalid = 0;
		s_tdata = 0;
		s_tuser = qfft_pkg::OP_WIN;
		burst_left = 0;
		hold_req = 0;
		arst_n = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// table edges, twiddle index wrap
		send_item(qfft_pkg::OP_WIN, 10'd1023, 16'h8000, 16'hffff);
		send_item(qfft_pkg::OP_WIN, 10'd0, 16'h7fff, 16'h0000);
		send_item(qfft_pkg::OP_TW, 10'd1023, 16'h7fff, 16'h8000);
		send_item(qfft_pkg::OP_TW, 10'd512, 16'h8000, 16'h7fff);
		for (int i = 0; i < qfft_pkg::FFT_SIZE; i++)
			send_item(qfft_pkg::OP_WIN, 10'(i), (i < 8) ? 16'h7fff : pick_value(),
				16'($urandom));
		for (int i = 0; i < qfft_pkg::FFT_SIZE/2; i++)
			send_item(qfft_pkg::OP_TW, {1'($urandom), 9'(i)}, pick_value(), pick_value());
		run_sample_frame();
		send_item(qfft_pkg::OP_READ, 10'd0, 16'h0, 16'h0);
		send_item(qfft_pkg::OP_READ, 10'd1023, 16'hffff, 16'hffff);
		send_item(qfft_pkg::OP_READ, 10'd512, 16'h8000, 16'h7fff);

		for (int n = 0; n < 250; n++) begin
			if (n == 100)
				hold_req = 1;
			r = $urandom_range(0, 99);
			if (r < 60)
				send_item(qfft_pkg::OP_SAMPLE, 10'($urandom), pick_value(), 16'($urandom));
			else if (r < 88)
				send_item(qfft_pkg::OP_READ, 10'($urandom), 16'($urandom), 16'($urandom));
			else if (r < 94)
				send_item(qfft_pkg::OP_WIN, 10'($urandom), pick_value(), 16'($urandom));
			else
				send_item(qfft_pkg::OP_TW, 10'($urandom), pick_value(), pick_value());
		end
		s_tvalid <= 0;

		while (pending != 0 || hold_req)
			@(posedge clk);
		repeat (200) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

`default_nettype wire
